// ----- rtl/core/rfa_pkg.sv -----
// Shared package for the rational fold accumulator.
// Holds the beat types, operation and status codes, and the shared-unit request and response types.
// No dependencies.
package rfa_pkg;

	localparam int DEF_VALUE_WIDTH = 32;

	localparam logic [1:0] MODE_SUM  = 2'd0;
	localparam logic [1:0] MODE_DIFF = 2'd1;
	localparam logic [1:0] MODE_PROD = 2'd2;
	localparam logic [1:0] MODE_QUOT = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

	localparam logic [1:0] ARITH_MUL = 2'd0;
	localparam logic [1:0] ARITH_DIV = 2'd1;
	localparam logic [1:0] ARITH_GCD = 2'd2;

	typedef struct packed {
		logic signed [31:0] numerator;
		logic signed [31:0] denominator;
		logic               last;
	} item_beat_t;

	typedef struct packed {
		logic signed [31:0] result_numerator;
		logic [30:0]        result_denominator;
		logic [1:0]         status;
	} result_beat_t;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} arith_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} arith_rsp_t;

endpackage

// ----- rtl/core/rfa_arith.sv -----
// Shared iterative arithmetic unit: limited multiply, restoring divide, binary GCD.
// One bit or one step per cycle. Depends on rfa_pkg.
module rfa_arith import rfa_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  arith_req_t                                  req,
	input  logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] a,
	input  logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] b,
	output arith_rsp_t                                  rsp,
	output logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] res
);

	localparam int MW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam int AW = MW + 2;
	localparam int CW = $clog2(MW + 1);
	localparam logic [MW-1:0] LIM = {MW{1'b1}} >> (MW - VALUE_WIDTH + 1);

	logic          busy_q;
	logic [1:0]    op_q;
	logic [MW-1:0] u_q;
	logic [MW-1:0] v_q;
	logic [AW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	logic          ovf_q;
	logic          done_q;
	logic [MW-1:0] res_q;

	logic [AW-1:0] mul_nxt;
	logic [AW-1:0] div_sh;

	assign mul_nxt = {acc_q[AW-2:0], 1'b0} + (v_q[MW-1] ? {2'b00, u_q} : {AW{1'b0}});
	assign div_sh  = {acc_q[AW-2:0], u_q[MW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ARITH_MUL;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			k_q    <= '0;
			u_q    <= '0;
			v_q    <= '0;
			acc_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				u_q    <= a;
				v_q    <= b;
				acc_q  <= '0;
				cnt_q  <= CW'(MW);
				k_q    <= '0;
				ovf_q  <= 1'b0;
			end else if (busy_q) begin
				unique case (op_q)
					ARITH_MUL: begin
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= acc_q[MW-1:0];
						end else begin
							if (!ovf_q) begin
								if (mul_nxt > {2'b00, LIM}) ovf_q <= 1'b1;
								else acc_q <= mul_nxt;
							end
							v_q   <= {v_q[MW-2:0], 1'b0};
							cnt_q <= cnt_q - 1'b1;
						end
					end
					ARITH_DIV: begin
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= u_q;
						end else begin
							if (div_sh >= {2'b00, v_q}) begin
								acc_q <= div_sh - {2'b00, v_q};
								u_q   <= {u_q[MW-2:0], 1'b1};
							end else begin
								acc_q <= div_sh;
								u_q   <= {u_q[MW-2:0], 1'b0};
							end
							cnt_q <= cnt_q - 1'b1;
						end
					end
					ARITH_GCD: begin
						if (u_q == v_q) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
							res_q  <= u_q << k_q;
						end else if (!u_q[0] && !v_q[0]) begin
							u_q <= u_q >> 1;
							v_q <= v_q >> 1;
							k_q <= k_q + 1'b1;
						end else if (!u_q[0]) begin
							u_q <= u_q >> 1;
						end else if (!v_q[0]) begin
							v_q <= v_q >> 1;
						end else if (u_q > v_q) begin
							u_q <= (u_q - v_q) >> 1;
						end else begin
							v_q <= (v_q - u_q) >> 1;
						end
					end
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						res_q  <= '0;
					end
				endcase
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign res      = res_q;

endmodule

// ----- rtl/core/rational_fold_accumulator_top.sv -----
// Top level of the rational fold accumulator.
// Holds the item sequencer, accumulator and result register. Depends on rfa_pkg, rfa_arith.
//
// Usage:
//   item channel (item_valid/item_stall/item) carries one fraction per beat;
//   result channel (result_valid/result_stall/result) carries one reduced
//   fraction with status after each beat marked last.
//   op_mode_valid/op_mode_ready/op_mode writes the fold mode; it is always
//   ready and the mode is sampled when an item beat is taken.
// Timing:
//   one item is worked on at a time by a single shared multiply/divide/GCD
//   unit, one bit or one GCD step per cycle. A zero-denominator item skips
//   the unit; a full item runs two GCDs, four divides and up to three
//   multiplies. item_stall stays high until the sequencer is back in idle.
// Reset:
//   accumulator clears to 0/1, flags clear, op_mode returns to sum.
// Stall:
//   a result beat holds in the output register while result_stall is high;
//   the next item is taken meanwhile, and the sequencer waits only when a
//   second result is ready before the first one leaves.
module rational_fold_accumulator_top import rfa_pkg::*; #(
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_stall,
	input  item_beat_t   item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_beat_t result,
	input  logic         op_mode_valid,
	output logic         op_mode_ready,
	input  logic [1:0]   op_mode
);

	localparam int MW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
	localparam logic [MW-1:0] LIM     = {MW{1'b1}} >> (MW - VALUE_WIDTH + 1);
	localparam logic [MW-1:0] OUT_MAX = MW'(32'h7FFF_FFFF);
	localparam logic [MW-1:0] ONE     = MW'(1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_IGCD  = 4'd2;
	localparam logic [3:0] S_IDIVN = 4'd3;
	localparam logic [3:0] S_IDIVD = 4'd4;
	localparam logic [3:0] S_ILIM  = 4'd5;
	localparam logic [3:0] S_M1    = 4'd6;
	localparam logic [3:0] S_M2    = 4'd7;
	localparam logic [3:0] S_M3    = 4'd8;
	localparam logic [3:0] S_COMB  = 4'd9;
	localparam logic [3:0] S_RGCD  = 4'd10;
	localparam logic [3:0] S_RDIVN = 4'd11;
	localparam logic [3:0] S_RDIVD = 4'd12;
	localparam logic [3:0] S_RLIM  = 4'd13;
	localparam logic [3:0] S_END   = 4'd14;

	logic [3:0]    state_q;
	logic [1:0]    mode_q;
	logic [1:0]    op_mode_q;
	logic          last_q;
	logic [MW-1:0] bn_q;
	logic [MW-1:0] bd_q;
	logic          bneg_q;
	logic [MW-1:0] g_q;
	logic [MW-1:0] p1_q;
	logic [MW-1:0] p2_q;
	logic [MW-1:0] p3_q;
	logic          ok_q;
	logic [MW-1:0] rn_q;
	logic [MW-1:0] rd_q;
	logic          rneg_q;
	logic          issued_q;

	logic [MW-1:0] acc_mag_q;
	logic [MW-1:0] acc_den_q;
	logic          acc_neg_q;
	logic          have_first_q;
	logic          ovf_seen_q;
	logic          zden_seen_q;

	logic         result_valid_q;
	result_beat_t result_q;

	arith_req_t    areq;
	arith_rsp_t    arsp;
	logic [MW-1:0] aa;
	logic [MW-1:0] ab;
	logic [MW-1:0] ares;

	logic          arith_state;
	logic          sumlike;
	logic          bs;
	logic [MW-1:0] rn_new;
	logic          rneg_new;
	logic [MW-1:0] rd_new;
	logic          out_free;
	logic          item_take;
	logic [31:0]   n_mag;
	logic [31:0]   d_mag;
	logic          out_wide;
	logic          out_fit;
	logic          out_ovf;
	logic [31:0]   out_num;
	logic          emit;

	rfa_arith #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.a      (aa),
		.b      (ab),
		.rsp    (arsp),
		.res    (ares)
	);

	assign arith_state = (state_q == S_IGCD) || (state_q == S_IDIVN) ||
		(state_q == S_IDIVD) || (state_q == S_M1) || (state_q == S_M2) ||
		(state_q == S_M3) || (state_q == S_RGCD) || (state_q == S_RDIVN) ||
		(state_q == S_RDIVD);
	assign sumlike    = (mode_q == MODE_SUM) || (mode_q == MODE_DIFF);

	always_comb begin
		areq.start = arith_state && !issued_q;
		aa         = bn_q;
		ab         = bd_q;
		areq.op    = ARITH_MUL;
		case (state_q)
			S_IGCD: begin
				aa = bn_q; ab = bd_q; areq.op = ARITH_GCD;
			end
			S_IDIVN: begin
				aa = bn_q; ab = g_q; areq.op = ARITH_DIV;
			end
			S_IDIVD: begin
				aa = bd_q; ab = g_q; areq.op = ARITH_DIV;
			end
			S_M1: begin
				aa = acc_mag_q; ab = (mode_q == MODE_PROD) ? bn_q : bd_q;
			end
			S_M2: begin
				if (sumlike) begin
					aa = bn_q; ab = acc_den_q;
				end else if (mode_q == MODE_PROD) begin
					aa = acc_den_q; ab = bd_q;
				end else begin
					aa = acc_den_q; ab = bn_q;
				end
			end
			S_M3: begin
				aa = acc_den_q; ab = bd_q;
			end
			S_RGCD: begin
				aa = rn_q; ab = rd_q; areq.op = ARITH_GCD;
			end
			S_RDIVN: begin
				aa = rn_q; ab = g_q; areq.op = ARITH_DIV;
			end
			S_RDIVD: begin
				aa = rd_q; ab = g_q; areq.op = ARITH_DIV;
			end
			default: begin
				aa = bn_q; ab = bd_q;
			end
		endcase
	end

	always_comb begin
		bs       = bneg_q ^ (mode_q == MODE_DIFF);
		rn_new   = p1_q;
		rneg_new = acc_neg_q ^ bneg_q;
		rd_new   = p2_q;
		if (sumlike) begin
			rd_new = p3_q;
			if (acc_neg_q == bs) begin
				rn_new   = p1_q + p2_q;
				rneg_new = acc_neg_q;
			end else if (p1_q >= p2_q) begin
				rn_new   = p1_q - p2_q;
				rneg_new = acc_neg_q;
			end else begin
				rn_new   = p2_q - p1_q;
				rneg_new = bs;
			end
		end
	end

	assign n_mag = item.numerator[31] ? (32'd0 - item.numerator) : item.numerator;
	assign d_mag = item.denominator[31] ? (32'd0 - item.denominator) : item.denominator;

	assign out_wide = have_first_q && ((acc_mag_q > OUT_MAX) || (acc_den_q > OUT_MAX));
	assign out_fit  = have_first_q && !out_wide;
	assign out_ovf  = ovf_seen_q || out_wide;
	assign out_num  = acc_neg_q ? (32'd0 - acc_mag_q[31:0]) : acc_mag_q[31:0];

	assign item_stall    = (state_q != S_IDLE);
	assign item_take     = item_valid && !item_stall;
	assign out_free      = !result_valid_q || !result_stall;
	assign emit          = (state_q == S_END) && last_q && out_free;
	assign op_mode_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= MODE_SUM;
		end else if (op_mode_valid && op_mode_ready) begin
			op_mode_q <= op_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			issued_q       <= 1'b0;
			mode_q         <= MODE_SUM;
			last_q         <= 1'b0;
			bn_q           <= '0;
			bd_q           <= ONE;
			bneg_q         <= 1'b0;
			g_q            <= '0;
			p1_q           <= '0;
			p2_q           <= '0;
			p3_q           <= '0;
			ok_q           <= 1'b1;
			rn_q           <= '0;
			rd_q           <= ONE;
			rneg_q         <= 1'b0;
			acc_mag_q      <= '0;
			acc_den_q      <= ONE;
			acc_neg_q      <= 1'b0;
			have_first_q   <= 1'b0;
			ovf_seen_q     <= 1'b0;
			zden_seen_q    <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (emit) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
			if (areq.start) issued_q <= 1'b1;
			else if (arsp.done) issued_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_take) begin
						mode_q  <= op_mode_q;
						last_q  <= item.last;
						bn_q    <= MW'(n_mag);
						bd_q    <= MW'(d_mag);
						bneg_q  <= item.numerator[31] ^ item.denominator[31];
						ok_q    <= 1'b1;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (bd_q == '0) begin
						zden_seen_q <= 1'b1;
						state_q     <= S_END;
					end else if (bn_q == '0) begin
						bd_q    <= ONE;
						bneg_q  <= 1'b0;
						state_q <= S_ILIM;
					end else begin
						state_q <= S_IGCD;
					end
				end
				S_IGCD: begin
					if (arsp.done) begin
						g_q     <= ares;
						state_q <= S_IDIVN;
					end
				end
				S_IDIVN: begin
					if (arsp.done) begin
						bn_q    <= ares;
						state_q <= S_IDIVD;
					end
				end
				S_IDIVD: begin
					if (arsp.done) begin
						bd_q    <= ares;
						state_q <= S_ILIM;
					end
				end
				S_ILIM: begin
					if ((bn_q > LIM) || (bd_q > LIM)) begin
						ovf_seen_q <= 1'b1;
						state_q    <= S_END;
					end else if (!have_first_q) begin
						acc_mag_q    <= bn_q;
						acc_den_q    <= bd_q;
						acc_neg_q    <= bneg_q;
						have_first_q <= 1'b1;
						state_q      <= S_END;
					end else if ((mode_q == MODE_QUOT) && (bn_q == '0)) begin
						state_q <= S_END;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: begin
					if (arsp.done) begin
						p1_q    <= ares;
						ok_q    <= ok_q && !arsp.ovf;
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (arsp.done) begin
						p2_q    <= ares;
						ok_q    <= ok_q && !arsp.ovf;
						state_q <= sumlike ? S_M3 : S_COMB;
					end
				end
				S_M3: begin
					if (arsp.done) begin
						p3_q    <= ares;
						ok_q    <= ok_q && !arsp.ovf;
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					if (!ok_q || (rd_new == '0)) begin
						ovf_seen_q <= 1'b1;
						state_q    <= S_END;
					end else if (rn_new == '0) begin
						rn_q    <= '0;
						rd_q    <= ONE;
						rneg_q  <= 1'b0;
						state_q <= S_RLIM;
					end else begin
						rn_q    <= rn_new;
						rd_q    <= rd_new;
						rneg_q  <= rneg_new;
						state_q <= S_RGCD;
					end
				end
				S_RGCD: begin
					if (arsp.done) begin
						g_q     <= ares;
						state_q <= S_RDIVN;
					end
				end
				S_RDIVN: begin
					if (arsp.done) begin
						rn_q    <= ares;
						state_q <= S_RDIVD;
					end
				end
				S_RDIVD: begin
					if (arsp.done) begin
						rd_q    <= ares;
						state_q <= S_RLIM;
					end
				end
				S_RLIM: begin
					if ((rn_q > LIM) || (rd_q > LIM)) begin
						ovf_seen_q <= 1'b1;
					end else begin
						acc_mag_q <= rn_q;
						acc_den_q <= rd_q;
						acc_neg_q <= rneg_q;
					end
					state_q <= S_END;
				end
				S_END: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						result_q.result_numerator   <= out_fit ? out_num : 32'd0;
						result_q.result_denominator <= out_fit ? acc_den_q[30:0] : 31'd1;
						result_q.status <= out_ovf ? STATUS_OVERFLOW :
							(zden_seen_q ? STATUS_ZERO_DEN : STATUS_OK);
						acc_mag_q    <= '0;
						acc_den_q    <= ONE;
						acc_neg_q    <= 1'b0;
						have_first_q <= 1'b0;
						ovf_seen_q   <= 1'b0;
						zden_seen_q  <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- dv/tb_rational_fold_accumulator_top.sv -----
// Self-checking bench for the rational fold accumulator: random fraction lists per fold mode.
// A scoreboard class predicts each list result; plain tasks drive the item and mode ports.
// Depends on rfa_pkg and rational_fold_accumulator_top.
module tb_rational_fold_accumulator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rfa_pkg::*;

	class fold_scoreboard;
		logic [1:0] mode;
		longint acc_num;
		longint unsigned acc_den;
		bit loaded, ovf_seen, zden_seen;
		result_beat_t pending[$];
		int mismatches, checked;

		function new();
			mode = MODE_SUM;
			clear();
		endfunction

		function void clear();
			acc_num = 0;
			acc_den = 1;
			loaded = 0;
			ovf_seen = 0;
			zden_seen = 0;
		endfunction

		function longint unsigned gcd(longint unsigned a, longint unsigned b);
			longint unsigned t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		function longint unsigned mul_cap(longint unsigned a, longint unsigned b, ref bit ok);
			longint unsigned lim;
			lim = 64'h7FFF_FFFF;
			if (a != 0 && b > lim / a) begin
				ok = 0;
				return 0;
			end
			return a * b;
		endfunction

		function void fold(logic [31:0] nraw, logic [31:0] draw);
			longint unsigned lim, bn, bd, an, ad, rn, rd, p1, p2, g;
			bit nneg, dneg, bneg, aneg, rneg, ok;
			lim = 64'h7FFF_FFFF;
			ok = 1;
			nneg = nraw[31];
			dneg = draw[31];
			bn = nneg ? {32'd0, -nraw} : {32'd0, nraw};
			bd = dneg ? {32'd0, -draw} : {32'd0, draw};
			if (bd == 0) begin
				zden_seen = 1;
				return;
			end
			bneg = nneg != dneg;
			if (bn == 0) begin
				bd = 1;
				bneg = 0;
			end else begin
				g = gcd(bn, bd);
				bn /= g;
				bd /= g;
			end
			if (bn > lim || bd > lim) begin
				ovf_seen = 1;
				return;
			end
			if (!loaded) begin
				acc_num = bneg ? -longint'(bn) : longint'(bn);
				acc_den = bd;
				loaded = 1;
				return;
			end
			aneg = acc_num < 0;
			an = aneg ? -acc_num : acc_num;
			ad = acc_den;
			case (mode)
				MODE_SUM, MODE_DIFF: begin
					if (mode == MODE_DIFF) bneg = !bneg;
					p1 = mul_cap(an, bd, ok);
					p2 = mul_cap(bn, ad, ok);
					rd = mul_cap(ad, bd, ok);
					if (aneg == bneg) begin
						rn = p1 + p2;
						rneg = aneg;
					end else if (p1 >= p2) begin
						rn = p1 - p2;
						rneg = aneg;
					end else begin
						rn = p2 - p1;
						rneg = bneg;
					end
				end
				MODE_PROD: begin
					rn = mul_cap(an, bn, ok);
					rd = mul_cap(ad, bd, ok);
					rneg = aneg != bneg;
				end
				default: begin
					if (bn == 0) return;
					rn = mul_cap(an, bd, ok);
					rd = mul_cap(ad, bn, ok);
					rneg = aneg != bneg;
				end
			endcase
			if (!ok || rd == 0) begin
				ovf_seen = 1;
				return;
			end
			if (rn == 0) begin
				rd = 1;
				rneg = 0;
			end else begin
				g = gcd(rn, rd);
				rn /= g;
				rd /= g;
			end
			if (rn > lim || rd > lim) begin
				ovf_seen = 1;
				return;
			end
			acc_num = rneg ? -longint'(rn) : longint'(rn);
			acc_den = rd;
		endfunction

		function void note_item(item_beat_t it);
			result_beat_t r;
			bit ovf;
			longint unsigned mag;
			fold(it.numerator, it.denominator);
			if (!it.last) return;
			ovf = ovf_seen;
			r.result_numerator = 0;
			r.result_denominator = 1;
			if (loaded) begin
				mag = acc_num < 0 ? -acc_num : acc_num;
				if (mag > 64'h7FFF_FFFF || acc_den > 64'h7FFF_FFFF) ovf = 1;
				else begin
					r.result_numerator = acc_num[31:0];
					r.result_denominator = acc_den[30:0];
				end
			end
			r.status = ovf ? STATUS_OVERFLOW : (zden_seen ? STATUS_ZERO_DEN : STATUS_OK);
			pending.push_back(r);
			clear();
		endfunction

		function void check_result(result_beat_t got);
			result_beat_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
						exp.result_numerator, exp.result_denominator, exp.status,
						got.result_numerator, got.result_denominator, got.status);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic item_valid = 0;
	logic item_stall;
	item_beat_t item = '0;
	logic result_valid;
	logic result_stall = 0;
	result_beat_t result;
	logic op_mode_valid = 0;
	logic op_mode_ready;
	logic [1:0] op_mode = MODE_SUM;

	fold_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;
	bit sending_done = 0;

	rational_fold_accumulator_top uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && !result_stall) sb.check_result(result);

	initial begin
		int gap;
		forever begin
			@(negedge clk);
			gap = ($urandom_range(3) == 0) ? $urandom_range(7) : 0;
			if (gap != 0) begin
				result_stall <= 1;
				repeat (gap) @(negedge clk);
			end
			result_stall <= 0;
		end
	end

	task automatic write_mode(logic [1:0] m);
		@(negedge clk);
		op_mode <= m;
		op_mode_valid <= 1;
		do @(posedge clk); while (!op_mode_ready);
		sb.mode = m;
		@(negedge clk);
		op_mode_valid <= 0;
	endtask

	task automatic send_item(logic [31:0] n, logic [31:0] d, logic l, bit bursty);
		int gap;
		gap = bursty ? 0 : $urandom_range(7);
		repeat (gap + 1) @(negedge clk);
		item.numerator <= n;
		item.denominator <= d;
		item.last <= l;
		item_valid <= 1;
		do @(posedge clk); while (item_stall);
		sb.note_item(item);
		items_sent++;
		@(negedge clk);
		item_valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val();
		case ($urandom_range(4))
			0: return $urandom_range(9) - 4;
			1: return $urandom_range(200) - 100;
			2: return $urandom_range(65535) - 32768;
			3: return $urandom;
			default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0001;
		endcase
	endfunction

	initial begin
		bit bursty;
		int len;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: extremes and special cases per mode
		for (int m = 0; m < 4; m++) begin
			write_mode(m[1:0]);
			send_item(32'h7FFF_FFFF, 1, 0, 0);
			send_item(32'h8000_0001, 32'h7FFF_FFFF, 1, 0);
			send_item(0, 5, 0, 0);
			send_item(3, 0, 0, 0);
			send_item(-6, -4, 1, 0);
			send_item(32'h8000_0000, 3, 1, 0);
			drain();
		end
		write_mode(MODE_QUOT);
		send_item(7, 3, 0, 0);
		send_item(0, 9, 0, 0);
		send_item(2, -5, 1, 0);
		send_item(1, 1, 1, 1);
		send_item(0, 0, 1, 0);
		drain();
		// random lists
		while (items_sent < 900) begin
			write_mode(2'($urandom_range(3)));
			for (int k = 0; k < 10; k++) begin
				len = $urandom_range(6);
				bursty = $urandom_range(4) == 0;
				for (int i = 0; i <= len; i++)
					send_item(rand_val(),
						$urandom_range(15) == 0 ? 32'd0 : rand_val(),
						i == len, bursty);
			end
			drain();
		end
		$display("covered %0d items in all four modes, %0d results checked",
			items_sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
